@@ rtl/msz_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package msz_pkg;

  // Store geometry
  localparam int MAX_RECORDS  = 256;
  localparam int RECORD_BYTES = 256;
  localparam int STORE_BYTES  = MAX_RECORDS * RECORD_BYTES;
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_WAVE  = 2'd1;
  localparam logic [1:0] OP_LEVEL = 2'd2;

  // Byte offsets within one record
  localparam logic [7:0] OFF_BOUND      = 8'h0C;
  localparam logic [7:0] OFF_BOUND_LAST = 8'h2B;
  localparam logic [7:0] OFF_WAVE       = 8'h2C;
  localparam logic [7:0] OFF_WAVE_NEXT  = 8'h2E;
  localparam logic [7:0] OFF_WAVE_DEF   = 8'h6A;
  localparam logic [7:0] OFF_ALT        = 8'h6B;
  localparam logic [7:0] OFF_LEVEL      = 8'h6C;
  localparam logic [7:0] OFF_ALT0       = 8'h6D;
  localparam logic [7:0] OFF_TAIL       = 8'h8B;

  // Key and level constants
  localparam logic [7:0] KEY_OPEN    = 8'h7F;
  localparam logic [7:0] LEVEL_NONE  = 8'd127;
  localparam logic [6:0] CENTRE_NONE = 7'h40;

  // Lookup command handed to the sequencer
  typedef struct packed {
    logic              op_wave;
    logic              rec_ok;
    logic [ADDR_W-1:0] base;
    logic [6:0]        note_key;
    logic [6:0]        key_centre;
  } msz_cmd_t;

  // Lookup result
  typedef struct packed {
    logic        wave_found;
    logic [14:0] wave_id;
    logic [7:0]  level_byte;
  } msz_res_t;

  // Sequencer status
  typedef struct packed {
    logic idle;
    logic done;
  } msz_sts_t;

endpackage

`default_nettype wire

@@ rtl/multisample_zone_lookup.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Multisample zone lookup.
// Input channel (in_valid/in_ready) carries one command per transfer:
// operation 0 writes byte_value at byte_offset of record record_index,
// 1 looks up the wave number for note_key, 2 looks up the zone level for
// note_key transposed by key_centre. Operation 3 is dropped.
// Config channel (cfg_valid/cfg_ready, always ready) loads record_count;
// write it only while no lookup is in flight.
// A byte write gives no result. A lookup of a record at or above
// record_count reads nothing from the store and goes straight to its
// result. A valid lookup uses the store's one read port: a level lookup
// first reads the last bound byte and, if it is below the key, reads the
// tail byte as its level; else the sequencer scans the bound bytes one a
// cycle, then reads up to three wave words for a wave lookup, or a wave
// word and at most a level byte. in_ready stays low while a lookup runs.
// The result sits in an output register (out_valid/out_ready). A new
// command is taken while it waits; if the receiver stalls, the next lookup
// holds at its end until the register frees.
// Reset clears record_count and all handshake state. Store contents are
// not cleared and are undefined until written.
module multisample_zone_lookup (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  record_index,
  input  wire logic [7:0]  byte_offset,
  input  wire logic [7:0]  byte_value,
  input  wire logic [6:0]  note_key,
  input  wire logic [6:0]  key_centre,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             wave_found,
  output logic [14:0]      wave_id,
  output logic [7:0]       level_byte
);

  import msz_pkg::*;

  logic [8:0]        record_count;
  logic              in_xfer;
  logic              start;
  logic              rec_in_range;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              take;
  logic              out_valid_next;
  msz_cmd_t          cmd;
  msz_sts_t          sts;
  msz_res_t          res;

  // Accept commands while the sequencer is idle
  assign in_ready = sts.idle;
  assign in_xfer  = in_valid && in_ready;
  assign start    = in_xfer && ((operation == OP_WAVE) || (operation == OP_LEVEL));

  assign rec_in_range = (32'(record_index) < 32'(MAX_RECORDS));

  // Build the lookup command
  assign cmd.op_wave    = (operation == OP_WAVE);
  assign cmd.rec_ok     = ({1'b0, record_index} < record_count) && rec_in_range;
  assign cmd.base       = ADDR_W'(32'(record_index) * 32'(RECORD_BYTES));
  assign cmd.note_key   = note_key;
  assign cmd.key_centre = key_centre;

  // Drop writes outside the store
  assign wr_en   = in_xfer && (operation == OP_WRITE) && rec_in_range
                && (32'(byte_offset) < 32'(RECORD_BYTES));
  assign wr_addr = ADDR_W'(32'(record_index) * 32'(RECORD_BYTES) + 32'(byte_offset));

  // Hold record_count
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      record_count <= 9'd0;
    end else if (cfg_valid && cfg_ready) begin
      record_count <= cfg_data;
    end
  end

  msz_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (byte_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  msz_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .take  (take),
    .sts   (sts),
    .res   (res),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Move a finished result into the output register when it frees
  assign take = sts.done && (!out_valid || out_ready);

  always_comb begin
    out_valid_next = out_valid;
    if (take) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wave_found <= res.wave_found;
      wave_id    <= res.wave_id;
      level_byte <= res.level_byte;
    end
  end

endmodule

`default_nettype wire

@@ rtl/msz_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/msz_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msz_engine (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire msz_pkg::msz_cmd_t         cmd,
  input  wire logic                      take,
  output msz_pkg::msz_sts_t              sts,
  output msz_pkg::msz_res_t              res,
  output logic [msz_pkg::ADDR_W-1:0]     raddr,
  input  wire logic [7:0]                rdata
);

  import msz_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_WHI     = 3'd2;
  localparam logic [2:0] S_WCHK    = 3'd3;
  localparam logic [2:0] S_LB2B    = 3'd4;
  localparam logic [2:0] S_LB2BCHK = 3'd5;
  localparam logic [2:0] S_LBYTE   = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]        state;
  logic              op_wave;
  logic [ADDR_W-1:0] base;
  logic [6:0]        cmp_key;
  logic [5:0]        scan_issue;
  logic              pend;
  logic [4:0]        pend_z;
  logic [4:0]        zone;
  logic [7:0]        zbyte;
  logic [7:0]        word_lo;
  logic [7:0]        word_off;
  logic [1:0]        word_sel;

  logic [4:0]        scan_last;
  logic              issuing;
  logic              hit;
  logic              scan_end;
  logic [4:0]        zone_now;
  logic              word_neg;
  logic [7:0]        zone_x2;
  logic [7:0]        zone_x1;
  logic [7:0]        fallback_off;
  logic [7:0]        off_sel;
  logic signed [8:0] tk_wide;
  logic [6:0]        tk_clamp;

  // Transpose the level key by the key centre and clamp to 0..127
  assign tk_wide = $signed({2'b00, cmd.note_key}) + $signed({2'b00, CENTRE_NONE})
                 - $signed({2'b00, cmd.key_centre});
  always_comb begin
    if (tk_wide[8]) begin
      tk_clamp = 7'd0;
    end else if (tk_wide[7]) begin
      tk_clamp = 7'h7F;
    end else begin
      tk_clamp = tk_wide[6:0];
    end
  end

  // Shared compare unit for the bound scan
  assign scan_last = op_wave ? 5'd31 : 5'd30;
  assign issuing   = (state == S_SCAN) && (scan_issue <= {1'b0, scan_last});
  assign hit       = pend && ((rdata >= {1'b0, cmp_key}) || (op_wave && (rdata >= KEY_OPEN)));
  assign scan_end  = pend && (hit || (pend_z == scan_last));
  assign zone_now  = hit ? pend_z : 5'd31;

  assign word_neg     = rdata[7];
  assign zone_x2      = {2'b00, zone, 1'b0};
  assign zone_x1      = {3'b000, zone};
  assign fallback_off = (word_sel == 2'd0) ? (OFF_WAVE_NEXT + zone_x2) : OFF_WAVE_DEF;

  // Select the byte offset read in this cycle
  always_comb begin
    off_sel = OFF_BOUND + {3'b000, scan_issue[4:0]};
    unique case (state)
      S_SCAN: begin
        if (scan_end) begin
          off_sel = OFF_WAVE + {2'b00, zone_now, 1'b0};
        end
      end
      S_WHI:     off_sel = word_off + 8'd1;
      S_WCHK: begin
        if (op_wave) begin
          off_sel = fallback_off;
        end else if (!word_neg) begin
          off_sel = OFF_LEVEL + zone_x1;
        end else if (zone == 5'd0) begin
          off_sel = OFF_ALT0;
        end else begin
          off_sel = OFF_ALT + zone_x1;
        end
      end
      S_LB2B:    off_sel = OFF_BOUND_LAST;
      S_LB2BCHK: off_sel = OFF_TAIL;
      default:   off_sel = OFF_BOUND + {3'b000, scan_issue[4:0]};
    endcase
  end

  assign raddr    = base + ADDR_W'(off_sel);
  assign sts.idle = (state == S_IDLE);
  assign sts.done = (state == S_DONE);

  // Sequence one lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend       <= 1'b0;
      scan_issue <= 6'd0;
      word_sel   <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_wave            <= cmd.op_wave;
            base               <= cmd.base;
            cmp_key            <= cmd.op_wave ? cmd.note_key : tk_clamp;
            res.wave_found     <= 1'b0;
            res.wave_id        <= 15'd0;
            res.level_byte     <= (cmd.op_wave || cmd.rec_ok) ? 8'd0 : LEVEL_NONE;
            scan_issue         <= 6'd0;
            pend               <= 1'b0;
            if (!cmd.rec_ok) begin
              state <= S_DONE;
            end else if (cmd.op_wave) begin
              state <= S_SCAN;
            end else begin
              state <= S_LB2B;
            end
          end
        end
        S_SCAN: begin
          if (issuing) begin
            scan_issue <= scan_issue + 6'd1;
          end
          pend   <= issuing;
          pend_z <= scan_issue[4:0];
          if (scan_end) begin
            zone     <= zone_now;
            word_off <= OFF_WAVE + {2'b00, zone_now, 1'b0};
            word_sel <= 2'd0;
            pend     <= 1'b0;
            if (hit) begin
              zbyte <= rdata;
            end
            state <= S_WHI;
          end
        end
        S_WHI: begin
          word_lo <= rdata;
          state   <= S_WCHK;
        end
        S_WCHK: begin
          if (op_wave) begin
            if (!word_neg) begin
              res.wave_found  <= 1'b1;
              res.wave_id     <= {rdata[6:0], word_lo};
              state           <= S_DONE;
            end else if ((zone == 5'd0) || (word_sel == 2'd2)) begin
              state <= S_DONE;
            end else begin
              word_off <= fallback_off;
              word_sel <= word_sel + 2'd1;
              state    <= S_WHI;
            end
          end else begin
            if (!word_neg || (zone == 5'd0) || (zbyte == KEY_OPEN)) begin
              state <= S_LBYTE;
            end else begin
              res.level_byte <= LEVEL_NONE;
              state          <= S_DONE;
            end
          end
        end
        S_LB2B: begin
          state <= S_LB2BCHK;
        end
        S_LB2BCHK: begin
          zbyte <= rdata;
          if (rdata < {1'b0, cmp_key}) begin
            state <= S_LBYTE;
          end else begin
            scan_issue <= 6'd0;
            pend       <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_LBYTE: begin
          res.level_byte <= rdata;
          state          <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("lookup started while sequencer busy");

  a_take_done: assert property (@(posedge clk) disable iff (rst)
    take |-> (state == S_DONE))
    else $error("result taken before lookup finished");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && pend) |-> (pend_z <= scan_last))
    else $error("bound scan ran past its last zone");

  a_zone0_no_fallback: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WCHK) && (zone == 5'd0)) |-> (word_sel == 2'd0))
    else $error("zone 0 took a fallback wave word");

  a_word_sel_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WHI) |=> (word_sel != 2'd3))
    else $error("fallback word select out of range");
`endif

endmodule

`default_nettype wire
